/* sv/salc_pkg.sv */
// Shared types, constants and helpers for the set-associative LRU cache core.
// No dependencies; imported by salc_set_mem, set_assoc_lru_cache_sim_core and the testbench files.
package salc_pkg;

    // Default sizing, handed to the top level's parameters
    localparam int SALC_MAX_SET_BITS = 8;
    localparam int SALC_MAX_WAYS     = 8;
    localparam int SALC_ADDR_WIDTH   = 32;

    localparam int ADDR_IN_W = 32;
    localparam int COUNT_W   = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [3:0] SET_BITS_RST    = 4'd4;
    localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_IFETCH = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_MISS_FILL  = 2'd1,
        OUT_MISS_EVICT = 2'd2,
        OUT_IGNORED    = 2'd3
    } outcome_t;

    typedef struct packed {
        action_t              action;
        logic [ADDR_IN_W-1:0] address;
    } cache_req_t;

    typedef struct packed {
        outcome_t           outcome;
        logic               extra_hit;
        logic [2:0]         way_used;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
    } cache_rsp_t;

    // Saturating increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

/* sv/set_assoc_lru_cache_sim.sv */
// Results are registered. The set row is read at the transfer edge; the lookup, the set
// write-back (not for fetches) and the output load follow when the output is free.
// One access in flight: the set memory read is followed by the lookup state, which
// writes the set row back to the same memory; the next access waits for that commit.
// A finished result waits in the output register while the next access is taken.
// Reset (aresetn, synchronous, active low): counters zero, config to defaults, and
// every set row marked empty at once by per-set valid flops; no clearing pass.
module set_assoc_lru_cache_sim_core
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = SALC_MAX_SET_BITS,
    parameter int MAX_WAYS     = SALC_MAX_WAYS,
    parameter int ADDR_WIDTH   = SALC_ADDR_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Access requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cache_req_t            s_data,

    // Results
    output logic                  m_valid,
    input  logic                  m_ready,
    output cache_rsp_t            m_data
);

    // Geometry of a set row
    localparam int SIW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;  // set index
    localparam int RW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;  // rank
    localparam int WIW   = RW;                                     // way index
    localparam int WCW   = $clog2(MAX_WAYS + 1);                   // way count
    localparam int EW    = 1 + ADDR_WIDTH + RW;                    // one way entry
    localparam int ROW_W = MAX_WAYS * EW;
    localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Config registers
    logic [3:0] set_bits_reg;
    logic [4:0] offset_bits_reg;
    logic [3:0] ways_in_use_reg;

    // Access held for the lookup state
    action_t               act_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic [SIW-1:0]        set_reg;

    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;
    logic [COUNT_W-1:0] miss_count_reg, miss_count_next;
    logic [COUNT_W-1:0] evict_count_reg, evict_count_next;

    logic       m_valid_reg, m_valid_next;
    cache_rsp_t m_data_reg, m_data_next;

    // Address split
    logic                  s_xfer;
    logic [3:0]            set_bits_eff;
    logic [5:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] addr_eff;
    logic [ADDR_WIDTH-1:0] addr_off;
    logic [ADDR_WIDTH-1:0] tag_in;
    logic [SIW-1:0]        set_in;
    logic [WCW-1:0]        ways_eff;

    // Lookup
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      wr_row;
    logic                  commit;
    logic                  out_free;
    logic                  v_w [MAX_WAYS];
    logic [ADDR_WIDTH-1:0] t_w [MAX_WAYS];
    logic [RW-1:0]         r_w [MAX_WAYS];
    logic                  hit_found;
    logic [WIW-1:0]        hit_way;
    logic                  free_found;
    logic [WIW-1:0]        free_way;
    logic [WIW-1:0]        vict_way;
    logic [RW-1:0]         vict_rank;
    logic [WIW-1:0]        sel_way;
    logic [RW:0]           age_limit;
    logic                  is_fetch;
    logic                  is_miss;

    assign s_xfer   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_LOOKUP) && out_free;
    assign is_fetch = (act_reg == ACT_IFETCH);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    //------------------------------------------------------------------
    // Config
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg    <= SET_BITS_RST;
            offset_bits_reg <= OFFSET_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[3:0];
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Clamp set bits and way count into range
    always_comb begin
        if (32'(set_bits_reg) > MAX_SET_BITS) begin
            set_bits_eff = 4'(MAX_SET_BITS);
        end else begin
            set_bits_eff = set_bits_reg;
        end
        if (ways_in_use_reg == 4'd0) begin
            ways_eff = WCW'(1);
        end else if (32'(ways_in_use_reg) > MAX_WAYS) begin
            ways_eff = WCW'(MAX_WAYS);
        end else begin
            ways_eff = WCW'(ways_in_use_reg);
        end
    end

    //------------------------------------------------------------------
    // Address split: offset | set | tag. Shifts past the top give zero.
    //------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < ADDR_WIDTH; i++) begin
            addr_eff[i] = (i < ADDR_IN_W) ? s_data.address[i] : 1'b0;
        end
        tag_shift = 6'(set_bits_eff) + 6'(offset_bits_reg);
        tag_in    = addr_eff >> tag_shift;
        addr_off  = addr_eff >> offset_bits_reg;
        for (int i = 0; i < SIW; i++) begin
            set_in[i] = addr_off[i] && (i < 32'(set_bits_eff));
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            act_reg <= s_data.action;
            tag_reg <= tag_in;
            set_reg <= set_in;
        end
    end

    //------------------------------------------------------------------
    // Set memory: read on transfer, write back on commit
    //------------------------------------------------------------------
    salc_set_mem #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ROW_W        (ROW_W)
    ) u_set_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_xfer),
        .rd_idx  (set_in),
        .rd_row  (rd_row),
        .wr_en   (commit && !is_fetch),
        .wr_idx  (set_reg),
        .wr_row  (wr_row)
    );

    //------------------------------------------------------------------
    // Lookup: tag compare across ways, free-way and victim choice
    //------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            v_w[i] = rd_row[i*EW];
            t_w[i] = rd_row[i*EW+1 +: ADDR_WIDTH];
            r_w[i] = rd_row[i*EW+1+ADDR_WIDTH +: RW];
        end

        // lowest-numbered matching way wins
        hit_found = 1'b0;
        hit_way   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if ((i < 32'(ways_eff)) && v_w[i] && (t_w[i] == tag_reg)) begin
                hit_found = 1'b1;
                hit_way   = WIW'(i);
            end
        end

        // highest-numbered invalid way wins
        free_found = 1'b0;
        free_way   = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if ((i < 32'(ways_eff)) && !v_w[i]) begin
                free_found = 1'b1;
                free_way   = WIW'(i);
            end
        end

        // oldest way; ties go to the lower way
        vict_way  = '0;
        vict_rank = r_w[0];
        for (int i = 1; i < MAX_WAYS; i++) begin
            if ((i < 32'(ways_eff)) && (r_w[i] > vict_rank)) begin
                vict_rank = r_w[i];
                vict_way  = WIW'(i);
            end
        end

        is_miss = !hit_found;
        if (hit_found) begin
            sel_way   = hit_way;
            age_limit = {1'b0, r_w[hit_way]};
        end else if (free_found) begin
            sel_way   = free_way;
            age_limit = (RW+1)'(MAX_WAYS);
        end else begin
            sel_way   = vict_way;
            age_limit = {1'b0, vict_rank};
        end

        // Updated row: touched way becomes newest, younger valid ways age
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WIW'(i) == sel_way) begin
                wr_row[i*EW]                   = 1'b1;
                wr_row[i*EW+1 +: ADDR_WIDTH]    = tag_reg;
                wr_row[i*EW+1+ADDR_WIDTH +: RW] = '0;
            end else begin
                wr_row[i*EW]                = v_w[i];
                wr_row[i*EW+1 +: ADDR_WIDTH] = t_w[i];
                if ((i < 32'(ways_eff)) && v_w[i] && ({1'b0, r_w[i]} < age_limit)
                        && (r_w[i] < RANK_MAX)) begin
                    wr_row[i*EW+1+ADDR_WIDTH +: RW] = r_w[i] + 1'b1;
                end else begin
                    wr_row[i*EW+1+ADDR_WIDTH +: RW] = r_w[i];
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Counters and result
    //------------------------------------------------------------------
    always_comb begin
        hit_count_next   = hit_count_reg;
        miss_count_next  = miss_count_reg;
        evict_count_next = evict_count_reg;
        if (commit && !is_fetch) begin
            if (!is_miss) begin
                hit_count_next = sat_inc(hit_count_reg);
            end else begin
                miss_count_next = sat_inc(miss_count_reg);
                if (!free_found) begin
                    evict_count_next = sat_inc(evict_count_reg);
                end
            end
            // modify: the store half always hits
            if (act_reg == ACT_MODIFY) begin
                hit_count_next = sat_inc(hit_count_next);
            end
        end

        m_data_next.hit_total      = hit_count_next;
        m_data_next.miss_total     = miss_count_next;
        m_data_next.eviction_total = evict_count_next;
        if (is_fetch) begin
            m_data_next.outcome   = OUT_IGNORED;
            m_data_next.extra_hit = 1'b0;
            m_data_next.way_used  = '0;
        end else begin
            if (!is_miss) begin
                m_data_next.outcome = OUT_HIT;
            end else if (free_found) begin
                m_data_next.outcome = OUT_MISS_FILL;
            end else begin
                m_data_next.outcome = OUT_MISS_EVICT;
            end
            m_data_next.extra_hit = (act_reg == ACT_MODIFY);
            m_data_next.way_used  = 3'(sel_way);
        end

        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= m_data_next;
        end
    end

    //------------------------------------------------------------------
    // Sequencer: one access in flight, IDLE -> LOOKUP -> IDLE
    //------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_xfer) state_next = ST_LOOKUP;
            ST_LOOKUP: if (commit) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            hit_count_reg   <= '0;
            miss_count_reg  <= '0;
            evict_count_reg <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            hit_count_reg   <= hit_count_next;
            miss_count_reg  <= miss_count_next;
            evict_count_reg <= evict_count_next;
        end
    end

`ifndef ASSERT_OFF
    // A new result only appears right after a lookup cycle
    a_result_from_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result raised without a lookup");

    // Evictions are a subset of misses
    a_evict_le_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        evict_count_reg <= miss_count_reg)
        else $error("eviction count exceeds miss count");

    // Hit counter never decreases
    a_hit_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> hit_count_reg >= $past(hit_count_reg))
        else $error("hit count went backward");
`endif

endmodule

/* sv/salc_set_mem.sv */
// Set memory: one row per set holding valid, tag and rank of every way.
// Depends on salc_pkg. Per-row valid flops make unwritten rows read as zero.
module salc_set_mem
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = SALC_MAX_SET_BITS,
    parameter int ROW_W        = 64
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          rd_en,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] rd_idx,
    output logic [ROW_W-1:0]                              rd_row,
    input  logic                                          wr_en,
    input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] wr_idx,
    input  logic [ROW_W-1:0]                              wr_row
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;

    logic [ROW_W-1:0]    mem [NUM_SETS];
    logic [NUM_SETS-1:0] row_vld_reg;
    logic [ROW_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= row_vld_reg[rd_idx];
            end
        end
    end

    // A never-written row reads as all invalid, rank zero
    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* tb/cache_lookup_checker.sv */
// Scoreboard for the set-associative LRU cache core: tracks config writes,
// predicts each access result and compares it against the result channel.
// Depends on salc_pkg for request/result types, outcome codes and sizes.
module cache_lookup_checker
    import salc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  cache_req_t            s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  cache_rsp_t            m_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_BITS_MAX = SALC_MAX_SET_BITS;
    localparam int WAYS_MAX     = SALC_MAX_WAYS;
    localparam int NUM_LINES    = (1 << SET_BITS_MAX) * WAYS_MAX;

    logic                 line_valid [NUM_LINES];
    logic [ADDR_IN_W-1:0] line_tag   [NUM_LINES];
    int                   lru_rank   [NUM_LINES];
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   misses;
    logic [COUNT_W-1:0]   evictions;
    logic [3:0]           set_bits_q;
    logic [4:0]           offset_bits_q;
    logic [3:0]           ways_q;
    cache_rsp_t           expected_rsp [$];

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1;
    endfunction

    // Make way mru the youngest; valid lines younger than limit age by one.
    function automatic void age_set(input int base, input int ways, input int mru,
                                    input int limit);
        int i;
        for (i = 0; i < ways; i++) begin
            if (i != mru && line_valid[base+i] && lru_rank[base+i] < limit &&
                lru_rank[base+i] < WAYS_MAX - 1)
                lru_rank[base+i] = lru_rank[base+i] + 1;
        end
        lru_rank[base+mru] = 0;
    endfunction

    function automatic outcome_t lookup_line(input int base, input int ways,
                                             input logic [ADDR_IN_W-1:0] tag,
                                             output int way);
        int i;
        int free_way;
        int victim;
        int oldest;
        bit have_free;
        have_free = 1'b0;
        free_way  = 0;
        for (i = 0; i < ways; i++) begin
            if (!line_valid[base+i]) begin
                free_way  = i;      // last one seen = highest-numbered
                have_free = 1'b1;
            end else if (line_tag[base+i] == tag) begin
                hits = count_up(hits);
                age_set(base, ways, i, lru_rank[base+i]);
                way = i;
                return OUT_HIT;
            end
        end
        misses = count_up(misses);
        if (have_free) begin
            line_valid[base+free_way] = 1'b1;
            line_tag[base+free_way]   = tag;
            age_set(base, ways, free_way, WAYS_MAX);
            way = free_way;
            return OUT_MISS_FILL;
        end
        evictions = count_up(evictions);
        victim = 0;
        oldest = 0;
        for (i = 0; i < ways; i++) begin
            if (i == 0 || lru_rank[base+i] > oldest) begin
                oldest = lru_rank[base+i];
                victim = i;
            end
        end
        line_tag[base+victim] = tag;
        age_set(base, ways, victim, oldest);
        way = victim;
        return OUT_MISS_EVICT;
    endfunction

    function automatic cache_rsp_t predict_access(input cache_req_t req);
        cache_rsp_t           rsp;
        logic [ADDR_IN_W-1:0] tag;
        logic [ADDR_IN_W-1:0] set_idx;
        int                   s;
        int                   b;
        int                   ways;
        int                   base;
        int                   way;
        s    = (set_bits_q > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_q;
        b    = offset_bits_q;
        ways = (ways_q == 0) ? 1 : (ways_q > WAYS_MAX) ? WAYS_MAX : ways_q;
        way  = 0;
        rsp  = '0;
        rsp.outcome = OUT_IGNORED;
        if (req.action != ACT_IFETCH) begin
            // shifts past the address width give zero: wide splits have tag 0
            tag     = req.address >> (s + b);
            set_idx = (req.address >> b) & ((32'd1 << s) - 32'd1);
            base    = set_idx * WAYS_MAX;
            rsp.outcome = lookup_line(base, ways, tag, way);
            if (req.action == ACT_MODIFY) begin
                // the store half always hits the line just looked up
                hits = count_up(hits);
                age_set(base, ways, way, lru_rank[base+way]);
                rsp.extra_hit = 1'b1;
            end
        end
        rsp.way_used       = way[2:0];
        rsp.hit_total      = hits;
        rsp.miss_total     = misses;
        rsp.eviction_total = evictions;
        return rsp;
    endfunction

    function automatic void report(input string what, input cache_rsp_t r);
        $display("  %s: outcome=%0d extra_hit=%0d way=%0d hits=%0d misses=%0d evictions=%0d",
                 what, r.outcome, r.extra_hit, r.way_used, r.hit_total, r.miss_total,
                 r.eviction_total);
    endfunction

    function automatic void check_result(input cache_rsp_t got);
        cache_rsp_t want;
        if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result transfer with nothing outstanding", $time);
                report("actual", got);
            end
            return;
        end
        want = expected_rsp.pop_front();
        if (got.outcome !== want.outcome || got.extra_hit !== want.extra_hit ||
            got.way_used !== want.way_used || got.hit_total !== want.hit_total ||
            got.miss_total !== want.miss_total ||
            got.eviction_total !== want.eviction_total) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result mismatch", $time);
                report("expected", want);
                report("actual  ", got);
            end
        end
    endfunction

    function automatic void clear_model();
        int i;
        for (i = 0; i < NUM_LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            lru_rank[i]   = 0;
        end
        hits          = '0;
        misses        = '0;
        evictions     = '0;
        set_bits_q    = SET_BITS_RST;
        offset_bits_q = OFFSET_BITS_RST;
        ways_q        = WAYS_IN_USE_RST;
        expected_rsp.delete();
    endfunction

    // Result side first: the core's latency keeps a result from ever
    // belonging to the request taken at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SET_BITS:    set_bits_q    = cfg_wdata[3:0];
                    CFG_OFFSET_BITS: offset_bits_q = cfg_wdata;
                    CFG_WAYS_IN_USE: ways_q        = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_rsp.push_back(predict_access(s_data));
        end
        outstanding = expected_rsp.size();
    end

endmodule

/* tb/set_assoc_lru_cache_sim_core_tb.sv */
// Testbench top for set_assoc_lru_cache_sim_core: clock, reset, config writes,
// request stimulus and result backpressure; cache_lookup_checker does the checking.
// Depends on salc_pkg, the core RTL and tb/cache_lookup_checker.sv.
module set_assoc_lru_cache_sim_core_tb
    import salc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // No-transfer cycles before the run is declared hung. Worst legit stall is
    // a long run of receiver idles at 86%, far below this.
    localparam int HANG_LIMIT = 5000;
    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    cache_req_t            s_data;
    logic                  m_valid;
    logic                  m_ready;
    cache_rsp_t            m_data;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;

    // Idle percentages for the request sender and result receiver
    int src_idle_pct;
    int sink_idle_pct;

    // Config as last written, used to aim addresses at a few sets and tags
    int sb_now;
    int ob_now;
    int wu_now;

    set_assoc_lru_cache_sim_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    cache_lookup_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver backpressure, redrawn every falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Hang detector: counts edges with no transfer of any kind
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= HANG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // One request transfer. Entered and left at a falling edge. Valid stays
    // high after the transfer so back-to-back requests need no toggle; the
    // next call either swaps the payload or drops valid for a gap.
    task automatic send_access(input action_t act, input logic [ADDR_IN_W-1:0] addr);
        cache_req_t req;
        req.action  = act;
        req.address = addr;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < src_idle_pct)
                @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    // Register write; the enable stays high, so the caller lowers it after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] sb,
                              input logic [CFG_DATA_W-1:0] ob,
                              input logic [CFG_DATA_W-1:0] wu);
        wait_idle();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_OFFSET_BITS, ob);
        write_reg(CFG_WAYS_IN_USE, wu);
        cfg_wr_en <= 1'b0;
        // set-bits and ways registers keep only their low four bits
        sb_now = sb[3:0];
        ob_now = ob;
        wu_now = wu[3:0];
    endtask

    // Mostly addresses built from a few tags over a few sets so hits, fills
    // and evictions all happen; some fully random ones to toggle every bit.
    function automatic logic [ADDR_IN_W-1:0] rand_address();
        logic [63:0] tag;
        logic [63:0] set_idx;
        logic [63:0] off;
        logic [63:0] full;
        int          s;
        int          ways;
        if ($urandom_range(99) < 12)
            return $urandom();
        s    = (sb_now > SALC_MAX_SET_BITS) ? SALC_MAX_SET_BITS : sb_now;
        ways = (wu_now == 0) ? 1 : (wu_now > SALC_MAX_WAYS) ? SALC_MAX_WAYS : wu_now;
        tag     = $urandom_range(0, ways + 2);
        set_idx = $urandom_range(0, 3);
        off     = $urandom();
        tag     = tag << (s + ob_now);
        set_idx = (set_idx & ((64'd1 << s) - 64'd1)) << ob_now;
        off     = off & ((64'd1 << ob_now) - 64'd1);
        full    = tag | set_idx | off;
        return full[ADDR_IN_W-1:0];
    endfunction

    task automatic run_random(input int count);
        int      n;
        int      r;
        action_t act;
        for (n = 0; n < count; n++) begin
            r   = $urandom_range(99);
            act = (r < 35) ? ACT_LOAD : (r < 65) ? ACT_STORE :
                  (r < 90) ? ACT_MODIFY : ACT_IFETCH;
            send_access(act, rand_address());
        end
    endtask

    initial begin
        int k;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        src_idle_pct  = 31;
        sink_idle_pct = 86;
        sb_now        = SET_BITS_RST;
        ob_now        = OFFSET_BITS_RST;
        wu_now        = WAYS_IN_USE_RST;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- Directed: reset config (16 sets, 16-byte blocks, one way) ----
        send_access(ACT_LOAD,   32'h0000_0000);  // cold miss, fills way 0
        send_access(ACT_LOAD,   32'h0000_000f);  // same block: hit
        send_access(ACT_STORE,  32'h0000_0100);  // same set, new tag: evict
        send_access(ACT_MODIFY, 32'h0000_0100);  // hit plus the store hit
        send_access(ACT_IFETCH, 32'hffff_ffff);  // ignored, counters only
        send_access(ACT_MODIFY, 32'hffff_ffff);  // miss into empty top set
        send_access(ACT_LOAD,   32'h0000_0000);  // evicts again

        // ---- Two sets, byte blocks, three ways: fill order and LRU victim ----
        set_config(5'd1, 5'd0, 5'd3);
        send_access(ACT_LOAD,   32'h0000_0000);  // fills highest free way
        send_access(ACT_LOAD,   32'h0000_0002);
        send_access(ACT_STORE,  32'h0000_0004);  // set now full
        send_access(ACT_LOAD,   32'h0000_0002);  // hit, reorders ranks
        send_access(ACT_LOAD,   32'h0000_0006);  // evicts least recent
        send_access(ACT_MODIFY, 32'h0000_0000);  // evicts next oldest
        send_access(ACT_LOAD,   32'h0000_0001);  // other set

        // Shrink to one way: upper ways ignored but kept, then brought back
        set_config(5'd1, 5'd0, 5'd1);
        send_access(ACT_LOAD,   32'h0000_0002);
        set_config(5'd1, 5'd0, 5'd3);
        send_access(ACT_LOAD,   32'h0000_0006);

        // Out-of-range values: set bits clamp to max (upper data bit dropped),
        // offset swallows the address so the tag is zero, zero ways acts as one
        set_config(5'h1f, 5'd31, 5'd0);
        send_access(ACT_LOAD,   32'hffff_ffff);
        send_access(ACT_STORE,  32'h8000_0000);
        send_access(ACT_IFETCH, 32'h0000_0000);

        // Largest documented split, ways above max clamp to max
        set_config(5'd8, 5'd23, 5'd15);
        send_access(ACT_LOAD,   32'hffff_ffff);
        send_access(ACT_LOAD,   32'h7fff_ffff);
        send_access(ACT_MODIFY, 32'h0080_0000);

        // Write to the unmapped index must leave the config alone
        wait_idle();
        write_reg(CFG_UNMAPPED, 5'h1f);
        cfg_wr_en <= 1'b0;
        send_access(ACT_LOAD,   32'h1234_5678);
        send_access(ACT_STORE,  32'ha5a5_a5a5);

        // ---- Random: three idle profiles, three configs each ----
        for (k = 0; k < 9; k++) begin
            if (k == 3) begin
                src_idle_pct  = 86;
                sink_idle_pct = 31;
            end
            if (k == 6) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (k)
                0: set_config(5'd0, 5'd0, 5'd8);    // one set, all ways
                1: set_config(5'd8, 5'd23, 5'd1);   // top of documented set and offset ranges
                2: set_config(5'd2, 5'd5, 5'd4);
                3: set_config(5'd15, 5'd31, 5'd0);  // set bits and ways clamped, offset swallows the address
                4: set_config(5'd3, 5'd2, 5'd15);
                5: set_config(5'd1, 5'd28, 5'd2);
                6: set_config(5'd4, 5'd4, 5'd8);
                7: set_config(5'd6, 5'd0, 5'd3);
                default: set_config(5'd0, 5'd12, 5'd7);
            endcase
            run_random(47);
        end

        // Drain, then wait on to catch any stray result
        wait_idle();
        repeat (12) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
